// ----- rtl/sncor_pkg.sv -----
// Shared types and constants of the sliding normalized correlator.
// Used by sncor_ctrl, sncor_dp, sncor_check and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sncor_pkg;

	localparam int ACC_W     = 64;
	localparam int COUNT_W   = 17;
	localparam int OUT_W     = 40;
	localparam int LAG_W     = 16;
	localparam int LEN_CFG_W = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int NORM_W    = 32;
	localparam int REM_W     = 66;
	localparam int QUO_W     = 33;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(34);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic OP_TEMPLATE = 1'b0;
	localparam logic OP_SIGNAL   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMPLATE_LENGTH = 2'd0,
		REG_NORMALIZE       = 2'd1,
		REG_FIRST_LAG       = 2'd2,
		REG_LAG_COUNT       = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAC, ST_DRAIN, ST_SQX, ST_SQMID, ST_SQY, ST_MUL, ST_DIV
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic mac_issue;
		logic sq_load;
		logic sq_sel_y;
		logic sq_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic issue_last;
		logic mac_busy;
		logic need_norm;
		logic sq_last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/sncor_ctrl.sv -----
// Controller state machine of the correlator: sequences MAC, square roots,
// division and result hand-off. Depends on sncor_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sncor_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sncor_pkg::sts_t sts,
	output sncor_pkg::cmd_t    cmd
);
	import sncor_pkg::*;

	ctl_state_t state_q, state_nx;
	logic accept;
	logic out_state;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// result is handed off from DRAIN (raw/zero) or at the end of DIV
	assign out_state = (state_q == ST_DRAIN && !sts.mac_busy && !sts.need_norm) ||
		(state_q == ST_DIV && sts.div_last);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.emit) state_nx = ST_MAC;
			end
			ST_MAC: begin
				if (sts.issue_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.mac_busy) begin
					if (sts.need_norm) state_nx = ST_SQX;
					else if (sts.out_free) state_nx = ST_IDLE;
				end
			end
			ST_SQX: begin
				if (sts.sq_last) state_nx = ST_SQMID;
			end
			ST_SQMID: state_nx = ST_SQY;
			ST_SQY: begin
				if (sts.sq_last) state_nx = ST_MUL;
			end
			ST_MUL: state_nx = ST_DIV;
			ST_DIV: begin
				if (sts.div_last && sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		case (state_q)
			ST_MAC: cmd.mac_issue = 1'b1;
			ST_DRAIN: begin
				cmd.sq_load = ~sts.mac_busy & sts.need_norm;
			end
			ST_SQX: cmd.sq_step = 1'b1;
			ST_SQMID: begin
				cmd.sq_load  = 1'b1;
				cmd.sq_sel_y = 1'b1;
			end
			ST_SQY: cmd.sq_step = 1'b1;
			ST_MUL: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = ~sts.div_last;
			default: cmd.accept = accept;
		endcase
		cmd.out_load = out_state & sts.out_free;
	end

endmodule
`default_nettype wire

// ----- rtl/sncor_dp.sv -----
// Datapath of the correlator: config registers, template and window memories,
// MAC pipeline, square root and Q2.30 divider, output register. Uses sncor_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sncor_dp #(
	parameter int TEMPLATE_DEPTH = 64,
	parameter int SAMPLE_WIDTH   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [sncor_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sncor_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              opcode,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
	input  wire sncor_pkg::cmd_t                   cmd,
	output sncor_pkg::sts_t                        sts,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sncor_pkg::LAG_W-1:0]            lag_index,
	output logic signed [sncor_pkg::OUT_W-1:0]     correlation,
	output logic                                   zero_energy,
	output logic                                   last
);
	import sncor_pkg::*;

	localparam int AW = $clog2(TEMPLATE_DEPTH);
	localparam int LW = $clog2(TEMPLATE_DEPTH + 1);
	localparam int CW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
	localparam int PW = 2 * SAMPLE_WIDTH;

	// configuration
	logic [LEN_CFG_W-1:0] len_cfg_q;
	logic                 norm_q;
	logic [LAG_W-1:0]     first_lag_q;
	logic [LAG_W-1:0]     lag_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q   <= LEN_CFG_W'(64);
			norm_q      <= 1'b0;
			first_lag_q <= '0;
			lag_count_q <= '1;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_TEMPLATE_LENGTH: len_cfg_q <= cfg_data[LEN_CFG_W-1:0];
				REG_NORMALIZE:       norm_q <= cfg_data[0];
				REG_FIRST_LAG:       first_lag_q <= cfg_data;
				REG_LAG_COUNT:       lag_count_q <= cfg_data;
				default:             norm_q <= norm_q;
			endcase
		end
	end

	// effective template length
	logic [CW-1:0] len_c;
	logic [LW-1:0] len_w;
	always_comb begin
		len_c = CW'(len_cfg_q);
		if (len_c == '0) len_c = CW'(1);
		else if (len_c > CW'(TEMPLATE_DEPTH)) len_c = CW'(TEMPLATE_DEPTH);
		len_w = LW'(len_c);
	end

	// request bookkeeping
	logic [LW-1:0]      fill_q, fill_eff;
	logic [COUNT_W-1:0] count_q, count_new, len17, start, off, first17, lag17;
	logic [AW-1:0]      wp_q, wp_new, base;
	logic [AW+1:0]      bdiff;
	logic               sig_acc, tpl_acc, emit, last_v;

	assign sig_acc   = cmd.accept & (opcode == OP_SIGNAL);
	assign tpl_acc   = cmd.accept & (opcode == OP_TEMPLATE);
	assign fill_eff  = (count_q != '0) ? '0 : fill_q;
	assign count_new = count_q + COUNT_W'(1);
	assign len17     = COUNT_W'(len_w);
	assign first17   = COUNT_W'(first_lag_q);
	assign lag17     = COUNT_W'(lag_count_q);
	assign start     = count_new - len17;
	assign off       = start - first17;
	assign emit      = (opcode == OP_SIGNAL) && (count_q != COUNT_MAX) &&
		(count_new >= len17) && (start >= first17) && (off < lag17);
	assign last_v    = (off == lag17 - COUNT_W'(1));
	assign wp_new    = (wp_q == AW'(TEMPLATE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign bdiff     = (AW+2)'(wp_new) - (AW+2)'(len_w);
	assign base      = bdiff[AW+1] ? AW'(bdiff + (AW+2)'(TEMPLATE_DEPTH)) : AW'(bdiff);

	// memories
	logic signed [SAMPLE_WIDTH-1:0] tmem [TEMPLATE_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] wmem [TEMPLATE_DEPTH];
	logic        [AW-1:0]           taddr_q, waddr_q;
	logic        [LW-1:0]           taps_q;
	logic signed [SAMPLE_WIDTH-1:0] t_s1, w_s1;

	always_ff @(posedge clk) begin
		if (tpl_acc && fill_eff < LW'(TEMPLATE_DEPTH)) tmem[AW'(fill_eff)] <= sample;
		if (cmd.mac_issue) t_s1 <= tmem[taddr_q];
	end

	always_ff @(posedge clk) begin
		if (sig_acc) wmem[wp_q] <= sample;
		if (cmd.mac_issue) w_s1 <= wmem[waddr_q];
	end

	logic [LAG_W-1:0] lag_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			wp_q    <= '0;
		end else if (tpl_acc) begin
			fill_q  <= (fill_eff < LW'(TEMPLATE_DEPTH)) ? fill_eff + LW'(1) : fill_eff;
			count_q <= '0;
		end else if (sig_acc) begin
			wp_q <= wp_new;
			if (count_q != COUNT_MAX) count_q <= count_new;
		end
	end

	always_ff @(posedge clk) begin
		if (sig_acc && emit) begin
			lag_q   <= start[LAG_W-1:0];
			last_q  <= last_v;
			taddr_q <= '0;
			waddr_q <= base;
			taps_q  <= len_w;
		end else if (cmd.mac_issue) begin
			taddr_q <= taddr_q + AW'(1);
			waddr_q <= (waddr_q == AW'(TEMPLATE_DEPTH - 1)) ? '0 : waddr_q + AW'(1);
			taps_q  <= taps_q - LW'(1);
		end
	end

	// MAC pipeline
	logic v_s1, v_s2;
	logic signed [PW-1:0] ptw_s2, ptt_s2, pww_s2;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0] ex_q, ey_q;
	logic signed [ACC_W:0] dsum;
	logic [ACC_W:0] xsum, ysum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ptw_s2 <= t_s1 * w_s1;
		ptt_s2 <= t_s1 * t_s1;
		pww_s2 <= w_s1 * w_s1;
	end

	assign dsum = (ACC_W+1)'(dot_q) + (ACC_W+1)'(ptw_s2);
	assign xsum = (ACC_W+1)'(ex_q) + (ACC_W+1)'($unsigned(ptt_s2));
	assign ysum = (ACC_W+1)'(ey_q) + (ACC_W+1)'($unsigned(pww_s2));

	always_ff @(posedge clk) begin
		if (sig_acc && emit) begin
			dot_q <= '0;
			ex_q  <= '0;
			ey_q  <= '0;
		end else if (v_s2) begin
			if (dsum[ACC_W] != dsum[ACC_W-1])
				dot_q <= dsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			else
				dot_q <= dsum[ACC_W-1:0];
			ex_q <= xsum[ACC_W] ? '1 : xsum[ACC_W-1:0];
			ey_q <= ysum[ACC_W] ? '1 : ysum[ACC_W-1:0];
		end
	end

	// shared square root, two bits per step
	logic [ACC_W-1:0]  sq_v_q, sq_r_q, sq_bit_q;
	logic [ACC_W:0]    sq_rb;
	logic [NORM_W-1:0] nx_q;

	assign sq_rb = (ACC_W+1)'(sq_r_q) + (ACC_W+1)'(sq_bit_q);

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			sq_v_q   <= cmd.sq_sel_y ? ey_q : ex_q;
			sq_r_q   <= '0;
			sq_bit_q <= ACC_W'(1) << (ACC_W - 2);
			if (cmd.sq_sel_y) nx_q <= sq_r_q[NORM_W-1:0];
		end else if (cmd.sq_step) begin
			if ((ACC_W+1)'(sq_v_q) >= sq_rb) begin
				sq_v_q <= sq_v_q - sq_rb[ACC_W-1:0];
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Q2.30 divider, one quotient bit per step after an overflow check
	logic [ACC_W-1:0]     den_q, mag;
	logic [REM_W-1:0]     rem_q, rx, dv;
	logic [QUO_W-1:0]     q_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 neg_q, sat_q;

	assign mag = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);

	always_comb begin
		rx = rem_q;
		dv = REM_W'(den_q);
		if (div_cnt_q == DIV_CNT_W'(1)) dv = REM_W'({den_q, 1'b0});
		else if (div_cnt_q > DIV_CNT_W'(2)) rx = rem_q << 1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			den_q     <= ACC_W'(nx_q) * ACC_W'(sq_r_q[NORM_W-1:0]);
			rem_q     <= REM_W'(mag);
			q_q       <= '0;
			div_cnt_q <= '0;
			neg_q     <= dot_q[ACC_W-1];
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (div_cnt_q == '0) begin
				sat_q <= rem_q >= REM_W'({den_q, 2'b00});
			end else if (rx >= dv) begin
				rem_q <= rx - dv;
				q_q   <= {q_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rx;
				q_q   <= {q_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	// result select
	logic [QUO_W:0]           qinc;
	logic [QUO_W-1:0]         qr;
	logic signed [NORM_W-1:0] nres;
	logic signed [OUT_W-1:0]  res;
	logic                     zero_e;

	assign qinc = (QUO_W+1)'(q_q) + (QUO_W+1)'(1);
	assign qr   = qinc[QUO_W:1];
	assign zero_e = norm_q & ((ex_q == '0) | (ey_q == '0));

	always_comb begin
		if (neg_q) begin
			if (sat_q || qr > QUO_W'(33'h0_8000_0000)) nres = {1'b1, {(NORM_W-1){1'b0}}};
			else nres = NORM_W'(-qr);
		end else begin
			if (sat_q || qr > QUO_W'(33'h0_7FFF_FFFF)) nres = {1'b0, {(NORM_W-1){1'b1}}};
			else nres = NORM_W'(qr);
		end
		if (zero_e) res = '0;
		else if (norm_q) res = OUT_W'(nres);
		else if (dot_q[ACC_W-1:OUT_W-1] == '0 || dot_q[ACC_W-1:OUT_W-1] == '1)
			res = dot_q[OUT_W-1:0];
		else res = dot_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			lag_index   <= lag_q;
			correlation <= res;
			zero_energy <= zero_e;
			last        <= last_q;
		end
	end

	assign sts.emit       = emit;
	assign sts.issue_last = (taps_q == LW'(1));
	assign sts.mac_busy   = v_s1 | v_s2;
	assign sts.need_norm  = norm_q & ~zero_e;
	assign sts.sq_last    = sq_bit_q[0];
	assign sts.div_last   = (div_cnt_q == DIV_LAST);
	assign sts.out_free   = ~out_valid | ~out_stall;

endmodule
`default_nettype wire

// ----- rtl/sliding_normalized_correlator.sv -----
// Top level of the sliding normalized correlator: controller plus datapath.
// Depends on sncor_pkg, sncor_ctrl and sncor_dp.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  opcode, sample
// out      output     out_valid/out_stall  lag_index, correlation, zero_energy, last
// cfg      input      cfg_write            cfg_index, cfg_data
//
// A template load or a sample without result completes when accepted; the
// controller stays idle. A raw result takes one MAC step per template tap,
// through a two-stage multiply pipeline fed by registered memory reads.
// Normalizing adds 2 x 32 square-root steps with a load state between them,
// one multiply, 34 divide steps and the hand-off.
// Reset clears control state only; no clearing pass. A stalled output holds
// the finished result until taken while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module sliding_normalized_correlator #(
	parameter int TEMPLATE_DEPTH = 64,
	parameter int SAMPLE_WIDTH   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [sncor_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sncor_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sncor_pkg::LAG_W-1:0]            lag_index,
	output logic signed [sncor_pkg::OUT_W-1:0]     correlation,
	output logic                                   zero_energy,
	output logic                                   last
);
	import sncor_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sncor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sncor_dp #(
		.TEMPLATE_DEPTH (TEMPLATE_DEPTH),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.sample      (sample),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.lag_index   (lag_index),
		.correlation (correlation),
		.zero_energy (zero_energy),
		.last        (last)
	);

endmodule
`default_nettype wire

// ----- rtl/sncor_check.sv -----
// Port-level assertion checker for the correlator, bound to the top level.
// Depends on sncor_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sncor_check (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [sncor_pkg::OUT_W-1:0] correlation,
	input wire logic                              zero_energy
);
	import sncor_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared right after a request");

	a_zero_energy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_energy |-> correlation == '0)
		else $error("zero energy with nonzero correlation");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("not ready after result load");

endmodule

bind sliding_normalized_correlator sncor_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.correlation (correlation),
	.zero_energy (zero_energy)
);
`default_nettype wire
